/* rtl/core/tseq_pkg.sv */
package tseq_pkg;

   // Field widths of one word
   localparam int STAMP_W      = 28;
   localparam int PAYLOAD_W    = 64;
   localparam int OP_W         = 3;
   localparam int IDX_W        = 6;
   localparam int FILL_LEVEL_W = 7;

   // Default queue depth
   localparam int TSEQ_DEPTH = 32;

   // Command codes
   localparam logic [OP_W-1:0] OP_INSERT      = 3'd0;
   localparam logic [OP_W-1:0] OP_DRAIN_BELOW = 3'd1;
   localparam logic [OP_W-1:0] OP_DRAIN_ABOVE = 3'd2;
   localparam logic [OP_W-1:0] OP_POP         = 3'd3;
   localparam logic [OP_W-1:0] OP_SUBTRACT    = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR       = 3'd5;

   // One stored event
   typedef struct packed {
      logic [STAMP_W-1:0]   stamp;
      logic [PAYLOAD_W-1:0] payload;
      logic                 artificial;
      logic                 ignored;
   } entry_type;

   // What a cell does with its entry this cycle
   typedef enum logic [2:0] {
      ACT_HOLD,
      ACT_LOAD,
      ACT_LEFT,
      ACT_RIGHT,
      ACT_SUB
   } cell_act_type;

   // Values broadcast to every cell
   typedef struct packed {
      entry_type          new_entry;
      logic [STAMP_W-1:0] key;
      logic [STAMP_W-1:0] delta;
   } cell_bus_type;

endpackage

/* rtl/core/tseq_cell.sv */
module tseq_cell import tseq_pkg::*; (
   input  logic         clock,
   input  cell_act_type act,
   input  cell_bus_type bus,
   input  entry_type    left_entry,
   input  entry_type    right_entry,
   output entry_type    entry,
   output logic         key_gt,
   output logic         key_lt
);

   entry_type entry_ff;
   entry_type entry_in;
   logic [STAMP_W-1:0] sub_stamp;

   // Compare against the broadcast key
   assign key_gt = entry_ff.stamp > bus.key;
   assign key_lt = entry_ff.stamp < bus.key;

   // Clamped subtract
   assign sub_stamp = (entry_ff.stamp > bus.delta) ? (entry_ff.stamp - bus.delta) : '0;

   // Next entry
   always_comb begin
      entry_in = entry_ff;
      unique case (act)
         ACT_HOLD:  entry_in = entry_ff;
         ACT_LOAD:  entry_in = bus.new_entry;
         ACT_LEFT:  entry_in = left_entry;
         ACT_RIGHT: entry_in = right_entry;
         ACT_SUB:   entry_in.stamp = sub_stamp;
         default:   entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

/* rtl/core/timestamp_sorted_event_queue.sv */
// A command is taken when start is high and busy low and held in the command register; the
// setup state then writes a status word to the result register, or for a drain or pop moves
// to the emit state, which puts one event per cycle on the rsp_ ports. The block stays busy
// until the last word is written and takes the next command only once idle again.
// Reset (synchronous) empties the queue and clears control; cell contents are not cleared.
// rsp_strobe marks each word for one cycle; the receiver cannot stall.
module timestamp_sorted_event_queue import tseq_pkg::*; #(
   parameter int DEPTH = TSEQ_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [OP_W-1:0]         req_op,
   input  logic [STAMP_W-1:0]      req_stamp,
   input  logic [PAYLOAD_W-1:0]    req_payload,
   input  logic                    req_artificial_flag,
   input  logic                    req_ignored_flag,
   input  logic [STAMP_W-1:0]      req_time_bound,
   input  logic [STAMP_W-1:0]      req_time_delta,
   input  logic [IDX_W-1:0]        req_pop_index,
   output logic                    rsp_strobe,
   output logic                    rsp_valid_res,
   output logic [STAMP_W-1:0]      rsp_out_stamp,
   output logic [PAYLOAD_W-1:0]    rsp_out_payload,
   output logic                    rsp_out_artificial,
   output logic                    rsp_out_ignored,
   output logic                    rsp_last,
   output logic [FILL_LEVEL_W-1:0] rsp_fill_level,
   output logic                    rsp_dropped
);

   localparam int FILL_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_EMIT
   } state_type;

   state_type state_ff;

   // Command register
   logic [OP_W-1:0]    op_ff;
   entry_type          new_ff;
   logic [STAMP_W-1:0] bound_ff;
   logic [STAMP_W-1:0] delta_ff;
   logic [IDX_W-1:0]   pidx_ff;

   // Queue control
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] rem_ff;
   logic [FILL_W-1:0] final_ff;
   logic [DEPTH-1:0]  mask_ff;

   // Result word
   logic                    rsp_strobe_ff;
   logic                    rsp_valid_ff;
   entry_type               rsp_entry_ff;
   logic                    rsp_last_ff;
   logic [FILL_LEVEL_W-1:0] rsp_fill_ff;
   logic                    rsp_dropped_ff;

   // Cell chain signals
   entry_type    cell_q [DEPTH];
   cell_act_type act [DEPTH];
   cell_bus_type bus;
   logic [DEPTH-1:0] gt;
   logic [DEPTH-1:0] lt;
   logic [DEPTH-1:0] occ;
   logic [DEPTH-1:0] ins;
   logic [DEPTH-1:0] lt_occ;
   logic [DEPTH-1:0] bnd;
   logic [DEPTH-1:0] pop_ge;
   logic [DEPTH-1:0] sel;

   logic              full;
   logic              pop_out;
   logic              do_insert;
   logic              do_sub;
   logic              do_emit;
   logic [FILL_W-1:0] n_lt;
   entry_type         emit_e;

   assign busy      = (state_ff != ST_IDLE);
   assign full      = (fill_ff == FILL_W'(DEPTH));
   assign pop_out   = ({1'b0, pidx_ff} >= FILL_LEVEL_W'(fill_ff));
   assign do_insert = (state_ff == ST_SETUP) && (op_ff == OP_INSERT) && !full;
   assign do_sub    = (state_ff == ST_SETUP) && (op_ff == OP_SUBTRACT);
   assign do_emit   = (state_ff == ST_EMIT);

   // Broadcast bus
   assign bus.new_entry = new_ff;
   assign bus.key       = (op_ff == OP_INSERT) ? new_ff.stamp : bound_ff;
   assign bus.delta     = delta_ff;

   // Capture command
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         op_ff             <= req_op;
         new_ff.stamp      <= req_stamp;
         new_ff.payload    <= req_payload;
         new_ff.artificial <= req_artificial_flag;
         new_ff.ignored    <= req_ignored_flag;
         bound_ff          <= req_time_bound;
         delta_ff          <= req_time_delta;
         pidx_ff           <= req_pop_index;
      end
   end

   // Cell chain
   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      entry_type left_e;
      entry_type right_e;
      logic      left_ins;
      logic      left_mask;
      logic      right_lt;

      if (gi == 0) begin : g_first
         assign left_e    = '0;
         assign left_ins  = 1'b0;
         assign left_mask = 1'b0;
      end else begin : g_mid
         assign left_e    = cell_q[gi-1];
         assign left_ins  = ins[gi-1];
         assign left_mask = mask_ff[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
         assign right_e  = '0;
         assign right_lt = 1'b0;
      end else begin : g_inner
         assign right_e  = cell_q[gi+1];
         assign right_lt = lt_occ[gi+1];
      end

      assign occ[gi]    = FILL_W'(gi) < fill_ff;
      // at or after the insert point: occupied and larger, or the first free cell
      assign ins[gi]    = occ[gi] ? gt[gi] : (FILL_W'(gi) == fill_ff);
      assign lt_occ[gi] = lt[gi] & occ[gi];
      assign bnd[gi]    = lt_occ[gi] & ~right_lt;
      assign pop_ge[gi] = FILL_LEVEL_W'(gi) >= {1'b0, pidx_ff};
      assign sel[gi]    = mask_ff[gi] & ~left_mask;

      always_comb begin
         act[gi] = ACT_HOLD;
         if (do_insert && ins[gi]) begin
            act[gi] = left_ins ? ACT_LEFT : ACT_LOAD;
         end else if (do_sub) begin
            act[gi] = ACT_SUB;
         end else if (do_emit && mask_ff[gi]) begin
            act[gi] = ACT_RIGHT;
         end
      end

      tseq_cell u_cell (
         .clock       (clock),
         .act         (act[gi]),
         .bus         (bus),
         .left_entry  (left_e),
         .right_entry (right_e),
         .entry       (cell_q[gi]),
         .key_gt      (gt[gi]),
         .key_lt      (lt[gi])
      );
   end

   // Count of leading entries below the key (thermometer edge encode)
   always_comb begin
      n_lt = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (bnd[i]) begin
            n_lt = n_lt | FILL_W'(i + 1);
         end
      end
   end

   // Head-of-shift select
   always_comb begin
      emit_e = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (sel[i]) begin
            emit_e = entry_type'(emit_e | cell_q[i]);
         end
      end
   end

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         fill_ff        <= '0;
         rem_ff         <= '0;
         final_ff       <= '0;
         mask_ff        <= '0;
         rsp_strobe_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_entry_ff   <= '0;
         rsp_last_ff    <= 1'b0;
         rsp_fill_ff    <= '0;
         rsp_dropped_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               state_ff       <= ST_IDLE;
               rsp_strobe_ff  <= 1'b1;
               rsp_valid_ff   <= 1'b0;
               rsp_entry_ff   <= '0;
               rsp_last_ff    <= 1'b1;
               rsp_dropped_ff <= 1'b0;
               rsp_fill_ff    <= FILL_LEVEL_W'(fill_ff);
               unique case (op_ff)
                  OP_INSERT: begin
                     if (full) begin
                        rsp_dropped_ff <= 1'b1;
                     end else begin
                        fill_ff     <= fill_ff + FILL_W'(1);
                        rsp_fill_ff <= FILL_LEVEL_W'(fill_ff + FILL_W'(1));
                     end
                  end
                  OP_DRAIN_BELOW: begin
                     if (n_lt != '0) begin
                        state_ff      <= ST_EMIT;
                        rsp_strobe_ff <= 1'b0;
                        mask_ff       <= '1;
                        rem_ff        <= n_lt;
                        final_ff      <= fill_ff - n_lt;
                     end
                  end
                  OP_DRAIN_ABOVE: begin
                     if (n_lt != fill_ff) begin
                        state_ff      <= ST_EMIT;
                        rsp_strobe_ff <= 1'b0;
                        mask_ff       <= ~lt_occ;
                        rem_ff        <= fill_ff - n_lt;
                        final_ff      <= n_lt;
                     end
                  end
                  OP_POP: begin
                     if (!pop_out) begin
                        state_ff      <= ST_EMIT;
                        rsp_strobe_ff <= 1'b0;
                        mask_ff       <= pop_ge;
                        rem_ff        <= FILL_W'(1);
                        final_ff      <= fill_ff - FILL_W'(1);
                     end
                  end
                  OP_CLEAR: begin
                     fill_ff     <= '0;
                     rsp_fill_ff <= '0;
                  end
                  default: ;
               endcase
            end
            ST_EMIT: begin
               rsp_strobe_ff  <= 1'b1;
               rsp_valid_ff   <= 1'b1;
               rsp_entry_ff   <= emit_e;
               rsp_last_ff    <= (rem_ff == FILL_W'(1));
               rsp_fill_ff    <= FILL_LEVEL_W'(final_ff);
               rsp_dropped_ff <= 1'b0;
               fill_ff        <= fill_ff - FILL_W'(1);
               rem_ff         <= rem_ff - FILL_W'(1);
               if (rem_ff == FILL_W'(1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_valid_res      = rsp_valid_ff;
   assign rsp_out_stamp      = rsp_entry_ff.stamp;
   assign rsp_out_payload    = rsp_entry_ff.payload;
   assign rsp_out_artificial = rsp_entry_ff.artificial;
   assign rsp_out_ignored    = rsp_entry_ff.ignored;
   assign rsp_last           = rsp_last_ff;
   assign rsp_fill_level     = rsp_fill_ff;
   assign rsp_dropped        = rsp_dropped_ff;

endmodule

/* rtl/core/tseq_checker.sv */
module tseq_checker import tseq_pkg::*; #(
   parameter int DEPTH = TSEQ_DEPTH
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_strobe,
   input logic                    rsp_valid_res,
   input logic                    rsp_last,
   input logic [FILL_LEVEL_W-1:0] rsp_fill_level,
   input logic                    rsp_dropped
);

   // A status word always closes its command
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_valid_res |-> rsp_last)
      else $error("status word without last");

   // A dropped insert reports a full queue and carries no event
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_dropped |-> !rsp_valid_res &&
         rsp_fill_level == FILL_LEVEL_W'(DEPTH))
      else $error("dropped insert with queue not full");

   // An accepted command makes the block busy in the following cycle, with no word out
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_strobe)
      else $error("command accepted but block not busy");

   // Nothing follows the last word directly
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe)
      else $error("word right after last");

   // Fill level never exceeds the depth
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_fill_level <= FILL_LEVEL_W'(DEPTH))
      else $error("fill level beyond depth");

endmodule

bind timestamp_sorted_event_queue tseq_checker #(.DEPTH(DEPTH)) u_tseq_checker (.*);
